### sv/hcbd_pkg.sv
// Shared types, constants and helpers for the HTTP body decoder.
`default_nettype none
package hcbd_pkg;

  localparam int unsigned MAX_SIZE_LINE = 1024;
  localparam int unsigned LINE_W = $clog2(MAX_SIZE_LINE + 1);

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LEN = 1'd1;

  localparam logic [1:0] MODE_CLOSE   = 2'd0;
  localparam logic [1:0] MODE_LENGTH  = 2'd1;
  localparam logic [1:0] MODE_CHUNKED = 2'd2;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_DIGIT = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_LONG     = 3'd3;
  localparam logic [2:0] ERR_CRLF     = 3'd4;
  localparam logic [2:0] ERR_CLOSE    = 3'd5;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STREAM  = 4'd1,
    PH_COUNT   = 4'd2,
    PH_LEAD    = 4'd3,
    PH_DIGITS  = 4'd4,
    PH_EXT     = 4'd5,
    PH_SIZE_CR = 4'd6,
    PH_DATA    = 4'd7,
    PH_DATA_CR = 4'd8,
    PH_DATA_LF = 4'd9,
    PH_DONE    = 4'd10,
    PH_ERROR   = 4'd11
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic [2:0] error_code;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  body_mode;
    logic [31:0] content_length;
  } cfg_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

### sv/hcbd_cfg.sv
// Configuration registers: body mode and content length.
`default_nettype none
module hcbd_cfg
  import hcbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  logic [1:0]  body_mode_r, body_mode_nxt;
  logic [31:0] content_length_r, content_length_nxt;

  always_comb begin
    body_mode_nxt      = body_mode_r;
    content_length_nxt = content_length_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BODY_MODE:   body_mode_nxt = cfg_wdata[1:0];
        CFG_CONTENT_LEN: content_length_nxt = cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= MODE_CLOSE;
      content_length_r <= 32'd0;
    end else begin
      body_mode_r      <= body_mode_nxt;
      content_length_r <= content_length_nxt;
    end
  end

  assign cfg.body_mode      = body_mode_r;
  assign cfg.content_length = content_length_r;

endmodule
`default_nettype wire

### sv/hcbd_step.sv
// Body parser state and the per-word decode step.
`default_nettype none
module hcbd_step
  import hcbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_word_t in_word,
  input  wire cfg_t     cfg,
  output out_word_t     result
);

  phase_t            phase_r, phase_nxt;
  logic [31:0]       bytes_left_r, bytes_left_nxt;
  logic [31:0]       size_accum_r, size_accum_nxt;
  logic              saw_digit_r, saw_digit_nxt;
  logic [LINE_W-1:0] line_length_r, line_length_nxt;

  logic [7:0] b;
  logic [4:0] hex;
  logic       is_hex, is_blank, is_cr, is_lf;
  logic       in_line, line_full, size_ovf, last_byte;

  assign b         = in_word.in_byte;
  assign hex       = hex_decode(b);
  assign is_hex    = hex[4];
  assign is_blank  = (b == CHAR_SPACE) || (b == CHAR_TAB);
  assign is_cr     = (b == CHAR_CR);
  assign is_lf     = (b == CHAR_LF);
  assign in_line   = (phase_r == PH_LEAD) || (phase_r == PH_DIGITS) ||
                     (phase_r == PH_EXT) || (phase_r == PH_SIZE_CR);
  assign line_full = (line_length_r >= LINE_W'(MAX_SIZE_LINE));
  assign size_ovf  = (size_accum_r[31:28] != 4'd0);
  assign last_byte = (bytes_left_r == 32'd1);

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    size_accum_nxt  = size_accum_r;
    saw_digit_nxt   = saw_digit_r;
    line_length_nxt = line_length_r;
    case (in_word.cmd)
      CMD_START: begin
        if (cfg.body_mode == MODE_CHUNKED) begin
          phase_nxt       = PH_LEAD;
          size_accum_nxt  = 32'd0;
          saw_digit_nxt   = 1'b0;
          line_length_nxt = '0;
        end else if (cfg.body_mode == MODE_LENGTH) begin
          bytes_left_nxt = cfg.content_length;
          phase_nxt = (cfg.content_length == 32'd0) ? PH_DONE : PH_COUNT;
        end else begin
          phase_nxt = PH_STREAM;
        end
      end
      CMD_CLOSE: begin
        if (phase_r == PH_STREAM) begin
          phase_nxt = PH_DONE;
        end else if (phase_r != PH_IDLE && phase_r != PH_DONE && phase_r != PH_ERROR) begin
          phase_nxt = PH_ERROR;
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_COUNT) begin
          bytes_left_nxt = bytes_left_r - 32'd1;
          if (last_byte) phase_nxt = PH_DONE;
        end else if (phase_r == PH_DATA) begin
          bytes_left_nxt = bytes_left_r - 32'd1;
          if (last_byte) phase_nxt = PH_DATA_CR;
        end else if (phase_r == PH_DATA_CR) begin
          phase_nxt = is_cr ? PH_DATA_LF : PH_ERROR;
        end else if (phase_r == PH_DATA_LF) begin
          if (is_lf) begin
            phase_nxt       = PH_LEAD;
            size_accum_nxt  = 32'd0;
            saw_digit_nxt   = 1'b0;
            line_length_nxt = '0;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end else if (in_line) begin
          if (line_full) begin
            phase_nxt = PH_ERROR;
          end else begin
            line_length_nxt = line_length_r + LINE_W'(1);
            if (is_cr) begin
              phase_nxt = PH_SIZE_CR;
            end else if (phase_r == PH_SIZE_CR) begin
              if (is_lf) begin
                if (!saw_digit_r) begin
                  phase_nxt = PH_ERROR;
                end else if (size_accum_r == 32'd0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  bytes_left_nxt = size_accum_r;
                  phase_nxt      = PH_DATA;
                end
              end else begin
                phase_nxt = PH_EXT;
              end
            end else if (phase_r != PH_EXT) begin
              if (is_hex) begin
                if (size_ovf) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  size_accum_nxt = {size_accum_r[27:0], hex[3:0]};
                  saw_digit_nxt  = 1'b1;
                  phase_nxt      = PH_DIGITS;
                end
              end else if (!(phase_r == PH_LEAD && is_blank)) begin
                phase_nxt = PH_EXT;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    result = '0;
    case (in_word.cmd)
      CMD_START: begin
        result.body_done = (cfg.body_mode == MODE_LENGTH) &&
                           (cfg.content_length == 32'd0);
      end
      CMD_CLOSE: begin
        if (phase_r == PH_STREAM) begin
          result.body_done = 1'b1;
        end else if (phase_r != PH_IDLE && phase_r != PH_DONE && phase_r != PH_ERROR) begin
          result.error_code = ERR_CLOSE;
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_STREAM || phase_r == PH_COUNT || phase_r == PH_DATA) begin
          result.payload_valid = 1'b1;
          result.payload_byte  = b;
          result.body_done     = (phase_r == PH_COUNT) && last_byte;
        end else if (phase_r == PH_DATA_CR) begin
          if (!is_cr) result.error_code = ERR_CRLF;
        end else if (phase_r == PH_DATA_LF) begin
          if (!is_lf) result.error_code = ERR_CRLF;
        end else if (in_line) begin
          if (line_full) begin
            result.error_code = ERR_LONG;
          end else if (!is_cr && phase_r == PH_SIZE_CR && is_lf) begin
            if (!saw_digit_r) result.error_code = ERR_NO_DIGIT;
            else if (size_accum_r == 32'd0) result.body_done = 1'b1;
          end else if (!is_cr && (phase_r == PH_LEAD || phase_r == PH_DIGITS) &&
                       is_hex && size_ovf) begin
            result.error_code = ERR_OVERFLOW;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_left_r  <= 32'd0;
      size_accum_r  <= 32'd0;
      saw_digit_r   <= 1'b0;
      line_length_r <= '0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      size_accum_r  <= size_accum_nxt;
      saw_digit_r   <= saw_digit_nxt;
      line_length_r <= line_length_nxt;
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COUNT || phase_r == PH_DATA) |-> (bytes_left_r != 32'd0))
    else $error("byte counter empty while data is expected");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_length_r <= LINE_W'(MAX_SIZE_LINE))
    else $error("size line length past limit");

  a_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (result.error_code != ERR_NONE) |-> (!result.payload_valid && !result.body_done))
    else $error("error raised together with data or done");

  a_err_enters_error: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && result.error_code != ERR_NONE) |=> (phase_r == PH_ERROR))
    else $error("error flagged but parser not in error phase");

endmodule
`default_nettype wire

### sv/http_chunked_body_decoder.sv
// Top level of the HTTP body decoder: input register, decode step, result register.
//
//   channel  dir  handshake             word
//   in_      in   in_valid / in_ready   in_word_t  {cmd, in_byte}
//   out_     out  out_valid / out_ready out_word_t {payload_valid, payload_byte,
//                                                   body_done, error_code}
//   cfg_     in   cfg_we                cfg_index, cfg_wdata
//
// One word per cycle sustained while out_ready stays high; each word taken is first
// registered in the input register, then decoded into the result register.
// The parser state updates once per word, in the decode step.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
// With out_ready low the result is held, the input register fills, and in_ready drops.
`default_nettype none
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_word_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_word_t  in_d_r;
  logic      in_v_r;
  out_word_t out_d_r;
  logic      out_v_r;
  out_word_t step_res;
  logic      step_en;

  hcbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hcbd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_word (in_d_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  assign step_en  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (step_en) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_d_r <= in_data;
    if (step_en) out_d_r <= step_res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_no_payload_garbage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_d_r.payload_valid) |-> (out_d_r.payload_byte == 8'd0))
    else $error("payload byte set without payload valid");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.body_done) |-> (out_d_r.error_code == ERR_NONE))
    else $error("body done reported with an error");

  a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> (in_v_r && (!out_v_r || out_ready)))
    else $error("decode step without input word or result room");

endmodule
`default_nettype wire
